FILE: rtl/core/bdq_pkg.sv
// bdq_pkg: shared constants and types for the bounded deque
// no dependencies; imported by bdq_cell and bounded_deque
package bdq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int OCC_W   = 5;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_LIST       = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // cell source select
  localparam logic [1:0] SEL_LEFT  = 2'd0;
  localparam logic [1:0] SEL_RIGHT = 2'd1;
  localparam logic [1:0] SEL_EXT   = 2'd2;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
  } cell_ctl_t;

endpackage

FILE: rtl/core/bdq_cell.sv
// bdq_cell: one storage cell of the deque chain
// depends on bdq_pkg for widths and the cell control struct
module bdq_cell
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  input  logic signed [DATA_W-1:0] ext,
  output logic signed [DATA_W-1:0] q
);

  logic signed [DATA_W-1:0] q_next;

  always_comb begin
    unique case (ctl.sel)
      SEL_LEFT:  q_next = left;
      SEL_RIGHT: q_next = right;
      SEL_EXT:   q_next = ext;
      default:   q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      q <= q_next;
    end
  end

endmodule

FILE: rtl/core/bounded_deque.sv
// bounded_deque: top level, a row of bdq_cell registers with front at cell 0
// depends on bdq_pkg and bdq_cell
//
// channel  | ports                                   | handshake
// ---------+-----------------------------------------+------------------------------
// command  | start, func, value, busy                | taken when start && !busy
// result   | done, elem, occupancy, status, last     | no stall
//
// push and pop give their result the cycle after the command, and a new command may be
// issued in that same cycle. unknown codes give no result.
// list with elements held raises busy after the command, one result per busy cycle
// as cells rotate through cell 0; the next command waits until busy falls again.
// rst is synchronous; it empties the deque and drops any list in progress.
// the receiver cannot stall, so results are never held back.
module bounded_deque
  import bdq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] value,
  output logic                     busy,
  output logic                     done,
  output logic signed [DATA_W-1:0] elem,
  output logic [OCC_W-1:0]         occupancy,
  output logic [STAT_W-1:0]        status,
  output logic                     last
);

  logic [CNT_W-1:0]         fill;
  logic [CNT_W-1:0]         fill_next;
  logic [CNT_W-1:0]         cnt;
  logic                     take;
  logic                     is_full;
  logic                     is_empty;
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  cell_ctl_t                ctl [DEPTH];
  logic signed [DATA_W-1:0] tail_val;
  logic signed [DATA_W-1:0] ext_val;

  assign take     = start && !busy;
  assign is_full  = (fill == CNT_W'(DEPTH));
  assign is_empty = (fill == '0);
  assign ext_val  = busy ? cell_q[0] : value;

  // pick the back element by one-hot compare against fill-1
  always_comb begin
    tail_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == fill) begin
        tail_val = tail_val | cell_q[i];
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    always_comb begin
      ctl[g] = '{en: 1'b0, sel: SEL_LEFT};
      if (busy) begin
        // rotate occupied cells toward the front, cell 0 wraps to the tail
        if (CNT_W'(g + 1) < fill) begin
          ctl[g] = '{en: 1'b1, sel: SEL_RIGHT};
        end else if (CNT_W'(g + 1) == fill) begin
          ctl[g] = '{en: 1'b1, sel: SEL_EXT};
        end
      end else if (take) begin
        if (func == OP_PUSH_FRONT && !is_full) begin
          ctl[g] = '{en: 1'b1, sel: SEL_LEFT};
        end else if (func == OP_PUSH_BACK && !is_full && CNT_W'(g) == fill) begin
          ctl[g] = '{en: 1'b1, sel: SEL_EXT};
        end else if (func == OP_POP_FRONT && !is_empty) begin
          ctl[g] = '{en: 1'b1, sel: SEL_RIGHT};
        end
      end
    end

    bdq_cell u_cell (
      .clk   (clk),
      .ctl   (ctl[g]),
      .left  ((g == 0) ? value : cell_q[(g == 0) ? 0 : g - 1]),
      .right ((g == DEPTH - 1) ? cell_q[g] : cell_q[(g == DEPTH - 1) ? g : g + 1]),
      .ext   (ext_val),
      .q     (cell_q[g])
    );
  end

  always_comb begin
    fill_next = fill;
    if (take) begin
      unique case (func)
        OP_PUSH_FRONT, OP_PUSH_BACK: if (!is_full)  fill_next = fill + 1'b1;
        OP_POP_FRONT,  OP_POP_BACK:  if (!is_empty) fill_next = fill - 1'b1;
        default:                     fill_next = fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      fill <= fill_next;
      done <= 1'b0;
      if (busy) begin
        done <= 1'b1;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else if (take) begin
        unique case (func)
          OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT, OP_POP_BACK: done <= 1'b1;
          OP_LIST: begin
            if (is_empty) begin
              done <= 1'b1;
            end else begin
              busy <= 1'b1;
              cnt  <= fill;
            end
          end
          default: done <= 1'b0;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (busy) begin
      elem      <= cell_q[0];
      occupancy <= OCC_W'(fill);
      status    <= ST_OK;
      last      <= (cnt == CNT_W'(1));
    end else if (take) begin
      elem      <= '0;
      occupancy <= OCC_W'(fill_next);
      last      <= 1'b1;
      status    <= ST_OK;
      priority case (func)
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (is_full) status <= ST_FULL;
        end
        OP_POP_FRONT: begin
          if (is_empty) status <= ST_EMPTY;
          else          elem   <= cell_q[0];
        end
        OP_POP_BACK: begin
          if (is_empty) status <= ST_EMPTY;
          else          elem   <= tail_val;
        end
        OP_LIST: begin
          if (is_empty) status <= ST_EMPTY;
        end
        default: status <= ST_OK;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill above capacity");

  a_list_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> (fill != '0) && (cnt != '0) && (cnt <= fill))
    else $error("list walk with bad count");

  a_list_end: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt == CNT_W'(1)) |=> (done && last && !busy))
    else $error("list walk did not end with last");

  a_cmd_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (func == OP_PUSH_FRONT || func == OP_PUSH_BACK ||
     func == OP_POP_FRONT || func == OP_POP_BACK)) |=> (done && last))
    else $error("missing result for transaction");
`endif

endmodule
